// ----- src/cbvp_pkg.sv -----
// Shared constants, register indexes and pipeline tag type for the
// cone-beam voxel projection unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbvp_pkg;

    // Default coordinate width (signed Q(n-17).16).
    localparam int COORD_WIDTH_DEF = 32;

    // Configuration register widths and reset values.
    localparam int TRIG_W  = 16;
    localparam int DIST_W  = 31;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 2;
    localparam logic [TRIG_W-1:0] SINE_RST   = 16'sd0;
    localparam logic [TRIG_W-1:0] COSINE_RST = 16'sd16384;
    localparam logic [DIST_W-1:0] DIST_RST   = 31'd65536;

    // Distance is aligned from scale 2^16 to scale 2^30.
    localparam int ALIGN_SH = 14;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        CFG_SINE   = 2'd0,
        CFG_COSINE = 2'd1,
        CFG_DIST   = 2'd2
    } t_cfg_idx;

    // Control bits that travel with each request down the pipeline.
    typedef struct packed {
        logic valid;
        logic invalid;
        logic neg;
    } t_tag;

endpackage
`default_nettype wire

// ----- src/cbvp_in_if.sv -----
// Input channel carrying one voxel position per request.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface cbvp_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] voxel_x;
    logic signed [COORD_WIDTH-1:0] voxel_y;
    logic signed [COORD_WIDTH-1:0] voxel_z;
    modport source (output valid, voxel_x, voxel_y, voxel_z, input ready);
    modport sink   (input valid, voxel_x, voxel_y, voxel_z, output ready);
endinterface
`default_nettype wire

// ----- src/cbvp_out_if.sv -----
// Output channel carrying detector coordinates per request.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface cbvp_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] det_u;
    logic signed [COORD_WIDTH-1:0] det_v;
    logic                          invalid;
    modport source (output valid, det_u, det_v, invalid, input ready);
    modport sink   (input valid, det_u, det_v, invalid, output ready);
endinterface
`default_nettype wire

// ----- src/cone_beam_voxel_projection_unit.sv -----
// Cone-beam voxel projection unit: top level with configuration registers,
// saturation and output register. Depends on cbvp_pkg, the channel
// interfaces, cbvp_front and cbvp_div.
//
// Usage: a voxel (x, y, z) request enters on i_vox and the detector
// coordinates (u, v) and an invalid flag leave on o_det, both valid/ready.
// Sine, cosine and source distance are written through the plain write
// port (index 0, 1, 2; other indexes are ignored), by the user only while
// the pipeline is empty; the block does not enforce this. A request passes
// five front stages, an overflow stage and one stage per quotient bit in
// each of the two parallel dividers, then the output register. Throughput
// is one request per cycle; every stage holds its own request and valid
// bit. When the receiver stalls with a result waiting, the whole pipeline
// freezes and i_vox.ready drops; nothing is lost or repeated. Bubbles in
// the pipeline still advance while the output register is empty. Reset
// clears all valid bits and loads sine 0, cosine 1.0, distance 1.0.
`timescale 1ns / 1ps
`default_nettype none
module cone_beam_voxel_projection_unit #(
    parameter int COORD_WIDTH = cbvp_pkg::COORD_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    cbvp_in_if.sink                          i_vox,
    cbvp_out_if.source                       o_det,
    input  wire                              i_cfg_we,
    input  wire  [cbvp_pkg::IDX_W-1:0]       i_cfg_idx,
    input  wire  [cbvp_pkg::CFG_W-1:0]       i_cfg_data
);
    localparam int CW    = COORD_WIDTH;
    localparam int MAG_W = CW + 48;
    localparam int DEN_W = ((CW + 16 > 45) ? CW + 16 : 45) + 2;

    // Configuration registers.
    logic signed [cbvp_pkg::TRIG_W-1:0] r_sin, r_cos;
    logic [cbvp_pkg::DIST_W-1:0]        r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin  <= cbvp_pkg::SINE_RST;
            r_cos  <= cbvp_pkg::COSINE_RST;
            r_dist <= cbvp_pkg::DIST_RST;
        end else if (i_cfg_we) begin
            unique case (cbvp_pkg::t_cfg_idx'(i_cfg_idx))
                cbvp_pkg::CFG_SINE:   r_sin  <= i_cfg_data[cbvp_pkg::TRIG_W-1:0];
                cbvp_pkg::CFG_COSINE: r_cos  <= i_cfg_data[cbvp_pkg::TRIG_W-1:0];
                cbvp_pkg::CFG_DIST:   r_dist <= i_cfg_data[cbvp_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless a result waits unread.
    logic r_out_valid, en;
    assign en          = !r_out_valid || o_det.ready;
    assign i_vox.ready = en;

    cbvp_pkg::t_tag   tag_u, tag_v, qtag_u, qtag_v;
    logic [MAG_W-1:0] u_mag, v_mag;
    logic [DEN_W-1:0] den;
    logic [CW-1:0]    q_u, q_v;
    logic             ovf_u, ovf_v;

    cbvp_front #(.COORD_WIDTH(CW), .MAG_W(MAG_W), .DEN_W(DEN_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_vox.valid),
        .i_x(i_vox.voxel_x), .i_y(i_vox.voxel_y), .i_z(i_vox.voxel_z),
        .i_sin(r_sin), .i_cos(r_cos), .i_dist(r_dist),
        .o_tag_u(tag_u), .o_tag_v(tag_v), .o_u_mag(u_mag), .o_v_mag(v_mag),
        .o_den(den)
    );

    cbvp_div #(.COORD_WIDTH(CW), .MAG_W(MAG_W), .DEN_W(DEN_W)) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_tag(tag_u),
        .i_mag(u_mag), .i_den(den), .o_tag(qtag_u), .o_quot(q_u), .o_ovf(ovf_u)
    );

    cbvp_div #(.COORD_WIDTH(CW), .MAG_W(MAG_W), .DEN_W(DEN_W)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_tag(tag_v),
        .i_mag(v_mag), .i_den(den), .o_tag(qtag_v), .o_quot(q_v), .o_ovf(ovf_v)
    );

    // Saturate, apply sign, and force zero for an invalid geometry.
    localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};
    logic [CW-1:0] lim_u, lim_v, mag_u, mag_v, n_u, n_v;

    always_comb begin
        lim_u = qtag_u.neg ? HALF : HALF - 1'b1;
        lim_v = qtag_v.neg ? HALF : HALF - 1'b1;
        mag_u = (ovf_u || q_u > lim_u) ? lim_u : q_u;
        mag_v = (ovf_v || q_v > lim_v) ? lim_v : q_v;
        n_u   = qtag_u.invalid ? '0 : (qtag_u.neg ? -mag_u : mag_u);
        n_v   = qtag_v.invalid ? '0 : (qtag_v.neg ? -mag_v : mag_v);
    end

    // Output register.
    logic [CW-1:0] r_det_u, r_det_v;
    logic          r_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= qtag_u.valid;
        end
        if (en) begin
            r_det_u   <= n_u;
            r_det_v   <= n_v;
            r_invalid <= qtag_u.invalid;
        end
    end

    assign o_det.valid   = r_out_valid;
    assign o_det.det_u   = r_det_u;
    assign o_det.det_v   = r_det_v;
    assign o_det.invalid = r_invalid;

`ifndef ASSERT_OFF
    // Both dividers must carry the same request in lockstep.
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qtag_u.valid == qtag_v.valid &&
        (!qtag_u.valid || qtag_u.invalid == qtag_v.invalid))
        else $error("divider pipelines out of step");

    // A waiting result freezes the input side.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_det.valid && !o_det.ready) |-> !i_vox.ready)
        else $error("input accepted while output stalled");

    // An invalid result carries zero coordinates.
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_det.valid && o_det.invalid) |-> (o_det.det_u == '0 && o_det.det_v == '0))
        else $error("invalid result with nonzero coordinates");
`endif

endmodule
`default_nettype wire

// ----- src/cbvp_front.sv -----
// Five-stage front end: products, denominator, numerators and magnitudes.
// Depends on cbvp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbvp_front #(
    parameter int COORD_WIDTH = cbvp_pkg::COORD_WIDTH_DEF,
    parameter int MAG_W       = COORD_WIDTH + 48,
    parameter int DEN_W       = 47
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  wire  signed [COORD_WIDTH-1:0]    i_x,
    input  wire  signed [COORD_WIDTH-1:0]    i_y,
    input  wire  signed [COORD_WIDTH-1:0]    i_z,
    input  wire  signed [cbvp_pkg::TRIG_W-1:0] i_sin,
    input  wire  signed [cbvp_pkg::TRIG_W-1:0] i_cos,
    input  wire  [cbvp_pkg::DIST_W-1:0]      i_dist,
    output cbvp_pkg::t_tag                   o_tag_u,
    output cbvp_pkg::t_tag                   o_tag_v,
    output logic [MAG_W-1:0]                 o_u_mag,
    output logic [MAG_W-1:0]                 o_v_mag,
    output logic [DEN_W-1:0]                 o_den
);
    localparam int PW   = COORD_WIDTH + cbvp_pkg::TRIG_W;
    localparam int ZW   = COORD_WIDTH + cbvp_pkg::DIST_W;
    localparam int NU_W = COORD_WIDTH + 17;
    localparam int LO_W = NU_W / 2;
    localparam int HI_W = NU_W - LO_W;
    localparam int PL_W = cbvp_pkg::DIST_W + LO_W;
    localparam int PH_W = cbvp_pkg::DIST_W + 1 + HI_W;

    // Stage 1: the five products.
    logic signed [PW-1:0] r_xc, r_ys, r_yc, r_xs;
    logic signed [ZW-1:0] r_zd1;
    logic                 r_v1;
    logic signed [cbvp_pkg::DIST_W:0] dist_s;
    assign dist_s = $signed({1'b0, i_dist});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_xc  <= i_x * i_cos;
            r_ys  <= i_y * i_sin;
            r_yc  <= i_y * i_cos;
            r_xs  <= i_x * i_sin;
            r_zd1 <= i_z * dist_s;
        end
    end

    // Stage 2: denominator and the u numerator term.
    logic signed [DEN_W-1:0] r_den2, d_sh;
    logic signed [NU_W-1:0]  r_nu;
    logic signed [ZW-1:0]    r_zd2;
    logic                    r_v2;
    assign d_sh = DEN_W'({i_dist, {cbvp_pkg::ALIGN_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_den2 <= d_sh - DEN_W'(r_xc) + DEN_W'(r_ys);
            r_nu   <= NU_W'(r_yc) - NU_W'(r_xs);
            r_zd2  <= r_zd1;
        end
    end

    // Stage 3: split product for u, validity check and magnitude of v.
    logic [LO_W-1:0]          nu_lo;
    logic signed [HI_W-1:0]   nu_hi;
    logic [ZW-1:0]            zd_abs;
    logic [PL_W-1:0]          r_plo;
    logic signed [PH_W-1:0]   r_phi;
    logic [DEN_W-1:0]         r_den3;
    logic [MAG_W-1:0]         r_vmag3;
    logic                     r_v3, r_inv3, r_vneg3;
    assign nu_lo  = r_nu[LO_W-1:0];
    assign nu_hi  = r_nu[NU_W-1:LO_W];
    assign zd_abs = r_zd2[ZW-1] ? ZW'(-r_zd2) : ZW'(r_zd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_plo   <= PL_W'(i_dist) * PL_W'(nu_lo);
            r_phi   <= dist_s * nu_hi;
            r_inv3  <= r_den2[DEN_W-1] || (r_den2 == '0);
            r_den3  <= r_den2;
            r_vneg3 <= r_zd2[ZW-1];
            r_vmag3 <= MAG_W'({zd_abs, {cbvp_pkg::ALIGN_SH{1'b0}}});
        end
    end

    // Stage 4: recombine the u numerator.
    logic signed [MAG_W-1:0] r_unum;
    logic [DEN_W-1:0]        r_den4;
    logic [MAG_W-1:0]        r_vmag4;
    logic                    r_v4, r_inv4, r_vneg4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_unum  <= (MAG_W'(r_phi) <<< LO_W) + $signed(MAG_W'(r_plo));
            r_den4  <= r_den3;
            r_inv4  <= r_inv3;
            r_vneg4 <= r_vneg3;
            r_vmag4 <= r_vmag3;
        end
    end

    // Stage 5: magnitude of u and the tags for both dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag_u.valid <= 1'b0;
            o_tag_v.valid <= 1'b0;
        end else if (i_en) begin
            o_tag_u.valid <= r_v4;
            o_tag_v.valid <= r_v4;
        end
        if (i_en) begin
            o_tag_u.invalid <= r_inv4;
            o_tag_u.neg     <= r_unum[MAG_W-1];
            o_tag_v.invalid <= r_inv4;
            o_tag_v.neg     <= r_vneg4;
            o_u_mag <= r_unum[MAG_W-1] ? MAG_W'(-r_unum) : MAG_W'(r_unum);
            o_v_mag <= r_vmag4;
            o_den   <= r_den4;
        end
    end

endmodule
`default_nettype wire

// ----- src/cbvp_div.sv -----
// Pipelined restoring divider: an overflow stage, then one quotient bit
// per stage. Depends on cbvp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbvp_div #(
    parameter int COORD_WIDTH = cbvp_pkg::COORD_WIDTH_DEF,
    parameter int MAG_W       = COORD_WIDTH + 48,
    parameter int DEN_W       = 47
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire  cbvp_pkg::t_tag    i_tag,
    input  wire  [MAG_W-1:0]        i_mag,
    input  wire  [DEN_W-1:0]        i_den,
    output cbvp_pkg::t_tag          o_tag,
    output logic [COORD_WIDTH-1:0]  o_quot,
    output logic                    o_ovf
);
    localparam int CW    = COORD_WIDTH;
    localparam int HW    = MAG_W - CW;
    localparam int CMP_W = (HW > DEN_W) ? HW : DEN_W;

    logic [DEN_W-1:0]  r_rem [CW+1];
    logic [DEN_W-1:0]  r_den [CW+1];
    logic [CW-1:0]     r_low [CW+1];
    logic [CW-1:0]     r_q   [CW+1];
    logic              r_ovf [CW+1];
    cbvp_pkg::t_tag    r_tag [CW+1];

    // Overflow stage: the quotient needs more than CW bits when the upper
    // part of the numerator already reaches the denominator.
    logic [HW-1:0] hi;
    assign hi = i_mag[MAG_W-1:CW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0].valid <= 1'b0;
        end else if (i_en) begin
            r_tag[0].valid <= i_tag.valid;
        end
        if (i_en) begin
            r_tag[0].invalid <= i_tag.invalid;
            r_tag[0].neg     <= i_tag.neg;
            r_ovf[0] <= CMP_W'(hi) >= CMP_W'(i_den);
            r_rem[0] <= DEN_W'(hi);
            r_den[0] <= i_den;
            r_low[0] <= i_mag[CW-1:0];
            r_q[0]   <= '0;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < CW; k++) begin : g_step
        logic [DEN_W-1:0] trial;
        logic             take;
        assign trial = {r_rem[k][DEN_W-2:0], r_low[k][CW-1]};
        assign take  = trial >= r_den[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1].valid <= 1'b0;
            end else if (i_en) begin
                r_tag[k+1].valid <= r_tag[k].valid;
            end
            if (i_en) begin
                r_tag[k+1].invalid <= r_tag[k].invalid;
                r_tag[k+1].neg     <= r_tag[k].neg;
                r_ovf[k+1] <= r_ovf[k];
                r_rem[k+1] <= take ? trial - r_den[k] : trial;
                r_den[k+1] <= r_den[k];
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][CW-2:0], take};
            end
        end
    end

    assign o_tag  = r_tag[CW];
    assign o_quot = r_q[CW];
    assign o_ovf  = r_ovf[CW];

endmodule
`default_nettype wire
